// File: hdl/gcode_line_word_lexer_macros.svh
// Assertion macros shared by the lexer checker.
`ifndef GCODE_LINE_WORD_LEXER_MACROS_SVH
`define GCODE_LINE_WORD_LEXER_MACROS_SVH

// Check that a condition holds at every edge out of reset.
`define GLL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a trigger leads to a consequence at the next edge.
`define GLL_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/gll_pkg.sv
// Shared constants, types and helper functions of the G-code word lexer.
`timescale 1ns / 1ps

package gll_pkg;

  localparam int FRACTION_DIGITS = 4;
  localparam int VALUE_BITS      = 40;
  localparam int QUEUE_DEPTH     = 3;

  typedef logic [VALUE_BITS-1:0] acc_t;

  localparam acc_t SAT_CAP     = acc_t'(1) << (VALUE_BITS - 1);
  localparam acc_t SAT_MAX     = SAT_CAP - acc_t'(1);
  localparam acc_t MUL10_LIMIT = SAT_CAP / 10;

  // Character codes
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  typedef enum logic [2:0] {
    MODE_EXPECT    = 3'd0,
    MODE_INT       = 3'd1,
    MODE_FRAC      = 3'd2,
    MODE_COMMENT   = 3'd3,
    MODE_DELETED   = 3'd4,
    MODE_MALFORMED = 3'd5,
    MODE_BADNUM    = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    KIND_WORD      = 3'd0,
    KIND_LINE_OK   = 3'd1,
    KIND_DELETED   = 3'd2,
    KIND_MALFORMED = 3'd3,
    KIND_BADNUM    = 3'd4
  } kind_e;

  // Lexer state carried between characters
  typedef struct packed {
    mode_e      mode;
    logic [6:0] letter;
    acc_t       acc;
    logic       neg;
    logic [2:0] frac_cnt;
    logic       digit_seen;
    logic       first;
  } lex_state_t;

  // Lexer state at line start after reset
  localparam lex_state_t LEX_RESET = '{
    mode:       MODE_EXPECT,
    letter:     '0,
    acc:        '0,
    neg:        1'b0,
    frac_cnt:   '0,
    digit_seen: 1'b0,
    first:      1'b1
  };

  // One result item
  typedef struct packed {
    kind_e                  kind;
    logic [6:0]             letter;
    logic [VALUE_BITS-1:0]  value;
    logic                   last;
  } res_t;

  // Results produced by one accepted character
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Powers of ten for digit weights
  function automatic logic [23:0] pow10(input logic [2:0] idx);
    logic [23:0] p;
    case (idx)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      default: p = 24'd10000000;
    endcase
    return p;
  endfunction

endpackage

// File: hdl/gll_in_if.sv
// Character channel: one raw line character per item.
`timescale 1ns / 1ps

interface gll_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       line_end;

  modport source (output valid, output char_code, output line_end, input ready);
  modport sink   (input valid, input char_code, input line_end, output ready);
endinterface

// File: hdl/gll_out_if.sv
// Result channel: one word or line-closing result per item.
`timescale 1ns / 1ps

interface gll_out_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         kind;
  logic [6:0]                         word_letter;
  logic signed [gll_pkg::VALUE_BITS-1:0] word_value;
  logic                               last_of_line;

  modport source (output valid, output kind, output word_letter, output word_value,
                  output last_of_line, input ready);
  modport sink   (input valid, input kind, input word_letter, input word_value,
                  input last_of_line, output ready);
endinterface

// File: hdl/gll_lex_core.sv
// Lexer state registers and the per-character word scanning logic.
`timescale 1ns / 1ps

module gll_lex_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      char_code_i,
  input  logic            line_end_i,
  output gll_pkg::push_t  push_o
);

  typedef struct packed {
    gll_pkg::lex_state_t st;
    logic                emit;
    gll_pkg::res_t       r;
  } close_t;

  gll_pkg::lex_state_t st_q, st_d;
  gll_pkg::push_t      push;

  // Saturating add, the sum never exceeds the cap
  function automatic gll_pkg::acc_t add_sat(input gll_pkg::acc_t a, input gll_pkg::acc_t b);
    gll_pkg::acc_t s;
    if (a >= gll_pkg::SAT_CAP || b > (gll_pkg::SAT_CAP - a)) begin
      s = gll_pkg::SAT_CAP;
    end else begin
      s = a + b;
    end
    return s;
  endfunction

  // Weight of one digit at a decimal position
  function automatic gll_pkg::acc_t digit_weight(input logic [3:0] d, input logic [2:0] pos);
    logic [27:0] prod;
    prod = 28'(d) * 28'(gll_pkg::pow10(pos));
    return gll_pkg::acc_t'(prod);
  endfunction

  // Drop the held word fields
  function automatic gll_pkg::lex_state_t clear_word(input gll_pkg::lex_state_t s);
    gll_pkg::lex_state_t o;
    o            = s;
    o.letter     = '0;
    o.acc        = '0;
    o.neg        = 1'b0;
    o.frac_cnt   = '0;
    o.digit_seen = 1'b0;
    return o;
  endfunction

  // Begin a word on a letter, anything else is malformed
  function automatic gll_pkg::lex_state_t start_word(input gll_pkg::lex_state_t s,
                                                     input logic [7:0] c);
    gll_pkg::lex_state_t o;
    o = s;
    if (c >= gll_pkg::CH_UP_A && c <= gll_pkg::CH_UP_Z) begin
      o        = clear_word(s);
      o.letter = c[6:0];
      o.mode   = gll_pkg::MODE_INT;
    end else begin
      o.mode = gll_pkg::MODE_MALFORMED;
    end
    return o;
  endfunction

  // End the number: emit the word or flag a bad number
  function automatic close_t close_number(input gll_pkg::lex_state_t s);
    close_t        o;
    gll_pkg::acc_t mag;
    o.st   = s;
    o.emit = 1'b0;
    o.r    = '0;
    mag    = s.acc;
    if (!s.digit_seen) begin
      o.st.mode = gll_pkg::MODE_BADNUM;
    end else begin
      o.emit     = 1'b1;
      o.r.kind   = gll_pkg::KIND_WORD;
      o.r.letter = s.letter;
      if (s.neg) begin
        o.r.value = ~mag + gll_pkg::acc_t'(1);
      end else if (mag > gll_pkg::SAT_MAX) begin
        o.r.value = gll_pkg::SAT_MAX;
      end else begin
        o.r.value = mag;
      end
      o.r.last  = 1'b0;
      o.st      = clear_word(s);
      o.st.mode = gll_pkg::MODE_EXPECT;
    end
    return o;
  endfunction

  // Scan one character against the current state
  always_comb begin
    logic [7:0]          c;
    logic                is_letter, is_digit, is_valid;
    logic [3:0]          d;
    logic [2:0]          fc_new;
    gll_pkg::acc_t       t;
    gll_pkg::lex_state_t s;
    close_t              cl;
    gll_pkg::res_t       fin;

    s      = st_q;
    push   = '0;
    cl     = '0;
    fin    = '0;
    t      = '0;
    fc_new = '0;
    c      = char_code_i;
    s.first = 1'b0;
    if (c >= gll_pkg::CH_LO_A && c <= gll_pkg::CH_LO_Z) begin
      c = c - gll_pkg::CASE_GAP;
    end
    is_letter = (c >= gll_pkg::CH_UP_A && c <= gll_pkg::CH_UP_Z);
    is_digit  = (c >= gll_pkg::CH_ZERO && c <= gll_pkg::CH_NINE);
    is_valid  = is_letter || is_digit || c == gll_pkg::CH_MINUS || c == gll_pkg::CH_POINT;
    d         = 4'(c - gll_pkg::CH_ZERO);

    if (st_q.first && c == gll_pkg::CH_SLASH) begin
      s.mode = gll_pkg::MODE_DELETED;
    end else if (s.mode inside {gll_pkg::MODE_EXPECT, gll_pkg::MODE_INT,
                                gll_pkg::MODE_FRAC}) begin
      if (c == gll_pkg::CH_LPAREN || c == gll_pkg::CH_SEMI) begin
        if (s.mode != gll_pkg::MODE_EXPECT) begin
          cl = close_number(s);
          s  = cl.st;
          if (cl.emit) begin
            push.r0    = cl.r;
            push.count = 2'd1;
          end
        end
        if (s.mode != gll_pkg::MODE_BADNUM) begin
          s.mode = gll_pkg::MODE_COMMENT;
        end
      end else if (is_valid) begin
        if (s.mode == gll_pkg::MODE_EXPECT) begin
          s = start_word(s, c);
        end else if (is_digit) begin
          if (s.mode == gll_pkg::MODE_INT) begin
            t = (s.acc > gll_pkg::MUL10_LIMIT) ? gll_pkg::SAT_CAP
                                                : (s.acc << 3) + (s.acc << 1);
            s.acc = add_sat(t, digit_weight(d, 3'(gll_pkg::FRACTION_DIGITS)));
          end else if (s.frac_cnt < 3'(gll_pkg::FRACTION_DIGITS)) begin
            fc_new     = s.frac_cnt + 3'd1;
            s.frac_cnt = fc_new;
            s.acc      = add_sat(s.acc,
                                 digit_weight(d, 3'(gll_pkg::FRACTION_DIGITS) - fc_new));
          end
          s.digit_seen = 1'b1;
        end else if (s.mode == gll_pkg::MODE_INT && c == gll_pkg::CH_POINT) begin
          s.mode = gll_pkg::MODE_FRAC;
        end else if (s.mode == gll_pkg::MODE_INT && c == gll_pkg::CH_MINUS &&
                     !s.digit_seen && !s.neg) begin
          s.neg = 1'b1;
        end else begin
          cl = close_number(s);
          s  = cl.st;
          if (cl.emit) begin
            push.r0    = cl.r;
            push.count = 2'd1;
          end
          if (s.mode == gll_pkg::MODE_EXPECT) begin
            s = start_word(s, c);
          end
        end
      end
    end

    // Close the line: flush an open number, then the closing result
    if (line_end_i) begin
      if (s.mode == gll_pkg::MODE_INT || s.mode == gll_pkg::MODE_FRAC) begin
        cl = close_number(s);
        s  = cl.st;
        if (cl.emit) begin
          push.r0    = cl.r;
          push.count = 2'd1;
        end
      end
      fin.last = 1'b1;
      case (s.mode)
        gll_pkg::MODE_DELETED:   fin.kind = gll_pkg::KIND_DELETED;
        gll_pkg::MODE_MALFORMED: fin.kind = gll_pkg::KIND_MALFORMED;
        gll_pkg::MODE_BADNUM:    fin.kind = gll_pkg::KIND_BADNUM;
        default:                 fin.kind = gll_pkg::KIND_LINE_OK;
      endcase
      if (push.count == 2'd0) begin
        push.r0 = fin;
      end else begin
        push.r1 = fin;
      end
      push.count = push.count + 2'd1;
      s          = clear_word(s);
      s.mode     = gll_pkg::MODE_EXPECT;
      s.first    = 1'b1;
    end

    st_d = s;
    if (!accept_i) begin
      push.count = 2'd0;
    end
  end

  // Advance the lexer state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= gll_pkg::LEX_RESET;
    end else if (accept_i) begin
      st_q <= st_d;
    end
  end

  assign push_o = push;

endmodule

// File: hdl/gll_out_queue.sv
// Three-slot result queue that takes up to two results per cycle.
`timescale 1ns / 1ps

module gll_out_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gll_pkg::push_t push_i,
  input  logic           pop_i,
  output logic           has_room_o,
  output logic           valid_o,
  output gll_pkg::res_t  head_o
);

  gll_pkg::res_t slots_q [gll_pkg::QUEUE_DEPTH];
  gll_pkg::res_t slots_d [gll_pkg::QUEUE_DEPTH];
  logic [1:0]    cnt_q, cnt_d;
  logic [1:0]    base;
  logic          pop;

  assign pop  = pop_i && (cnt_q != 2'd0);
  assign base = cnt_q - {1'b0, pop};

  // Shift out the head, then append the new results
  always_comb begin
    slots_d[0] = pop ? slots_q[1] : slots_q[0];
    slots_d[1] = pop ? slots_q[2] : slots_q[1];
    slots_d[2] = slots_q[2];
    for (int i = 0; i < gll_pkg::QUEUE_DEPTH; i++) begin
      if (push_i.count != 2'd0 && base == 2'(i)) begin
        slots_d[i] = push_i.r0;
      end
      if (push_i.count == 2'd2 && 2'(base + 2'd1) == 2'(i)) begin
        slots_d[i] = push_i.r1;
      end
    end
    cnt_d = base + push_i.count;
  end

  // Hold the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Hold the result payloads
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < gll_pkg::QUEUE_DEPTH; i++) begin
      slots_q[i] <= slots_d[i];
    end
  end

  assign has_room_o = (cnt_q <= 2'd1);
  assign valid_o    = (cnt_q != 2'd0);
  assign head_o     = slots_q[0];

endmodule

// File: hdl/gcode_line_word_lexer.sv
// Results: each result is written into the result queue and offered from its head.
// Throughput: one character per cycle while the result queue has room; a character that closes a word and the line
//   at once yields two results, so the three-slot result queue then holds input back until results drain.
// Reset: asynchronous, active low; the lexer returns to line start, queue empties.
// Top level of the G-code line word lexer.
`timescale 1ns / 1ps

module gcode_line_word_lexer (
  input  logic      clk_i,
  input  logic      rst_ni,
  gll_in_if.sink    items_i,
  gll_out_if.source words_o
);

  gll_pkg::push_t push;
  gll_pkg::res_t  head;
  logic           has_room;
  logic           accept;

  assign items_i.ready = has_room;
  assign accept        = items_i.valid && has_room;

  gll_lex_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_code_i (items_i.char_code),
    .line_end_i  (items_i.line_end),
    .push_o      (push)
  );

  gll_out_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pop_i      (words_o.ready),
    .has_room_o (has_room),
    .valid_o    (words_o.valid),
    .head_o     (head)
  );

  // Drive the result channel from the queue head
  assign words_o.kind         = head.kind;
  assign words_o.word_letter  = head.letter;
  assign words_o.word_value   = head.value;
  assign words_o.last_of_line = head.last;

endmodule

// File: hdl/gll_checker.sv
// Port-level checker of the lexer and its bind to the top level.
`timescale 1ns / 1ps
`include "gcode_line_word_lexer_macros.svh"

module gll_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_line_end_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] out_kind_i,
  input logic [6:0] out_letter_i,
  input logic       out_last_i
);

  logic in_fire, out_stall, is_word;

  assign in_fire   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;
  assign is_word   = (out_kind_i == 3'(gll_pkg::KIND_WORD));

  `GLL_ASSERT_NEXT(a_out_valid_holds, out_stall, out_valid_i, "result valid dropped while stalled")
  `GLL_ASSERT_NEXT(a_eol_gives_result, in_fire && in_line_end_i, out_valid_i, "no result after line end")
  `GLL_ASSERT_ALWAYS(a_word_shape, !(out_valid_i && is_word) || (!out_last_i && out_letter_i >= 7'h41 && out_letter_i <= 7'h5A), "bad word result")
  `GLL_ASSERT_ALWAYS(a_close_shape, !(out_valid_i && out_last_i) || (!is_word && out_letter_i == 7'd0), "bad closing result")

endmodule

bind gcode_line_word_lexer gll_checker u_gll_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (items_i.valid),
  .in_ready_i    (items_i.ready),
  .in_line_end_i (items_i.line_end),
  .out_valid_i   (words_o.valid),
  .out_ready_i   (words_o.ready),
  .out_kind_i    (words_o.kind),
  .out_letter_i  (words_o.word_letter),
  .out_last_i    (words_o.last_of_line)
);
